// ----- rtl/rv32i_execute_unit_macros.svh -----
// ----------------------------------------------------------------------------
// rv32i_execute_unit assertion macros
// Shared concurrent check forms, clocked on i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RV32I_EXECUTE_UNIT_MACROS_SVH
`define RV32I_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication
`define RVX_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RVX_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rvx_pkg.sv -----
// ----------------------------------------------------------------------------
// rvx_pkg
// Types and constants shared by the RV32I execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvx_pkg;

    typedef enum logic [5:0] {
        OP_ADDI  = 6'd0,  OP_SLTI  = 6'd1,  OP_SLTIU = 6'd2,  OP_ANDI  = 6'd3,
        OP_ORI   = 6'd4,  OP_XORI  = 6'd5,  OP_SLLI  = 6'd6,  OP_SRLI  = 6'd7,
        OP_SRAI  = 6'd8,  OP_LB    = 6'd9,  OP_LH    = 6'd10, OP_LW    = 6'd11,
        OP_LBU   = 6'd12, OP_LHU   = 6'd13, OP_JALR  = 6'd14, OP_ADD   = 6'd15,
        OP_SUB   = 6'd16, OP_SLT   = 6'd17, OP_SLTU  = 6'd18, OP_AND   = 6'd19,
        OP_OR    = 6'd20, OP_XOR   = 6'd21, OP_SLL   = 6'd22, OP_SRL   = 6'd23,
        OP_SRA   = 6'd24, OP_SB    = 6'd25, OP_SH    = 6'd26, OP_SW    = 6'd27,
        OP_BGE   = 6'd28, OP_BLT   = 6'd29, OP_BGEU  = 6'd30, OP_BLTU  = 6'd31,
        OP_BEQ   = 6'd32, OP_BNE   = 6'd33, OP_LUI   = 6'd34, OP_AUIPC = 6'd35,
        OP_JAL   = 6'd36
    } t_op;

    typedef enum logic [2:0] {
        CL_ALU, CL_LOAD, CL_STORE, CL_BRANCH, CL_JUMP, CL_NONE
    } t_cls;

    typedef enum logic [1:0] {
        MS_BYTE, MS_HALF, MS_WORD
    } t_msize;

    typedef enum logic [1:0] {
        ST_RD, ST_EX, ST_WB
    } t_state;

    localparam logic [1:0]  ACC_NONE   = 2'd0;
    localparam logic [1:0]  ACC_LOAD   = 2'd1;
    localparam logic [1:0]  ACC_STORE  = 2'd2;
    localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

    typedef struct packed {
        t_op         op;
        t_cls        cls;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
    } t_uop;

    typedef struct packed {
        logic        re;
        logic        we;
        t_msize      size;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_mem_req;

endpackage

// ----- rtl/rvx_front.sv -----
// ----------------------------------------------------------------------------
// rvx_front
// Accepts instruction transactions, classifies them and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hold,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [55:0]       i_s_tdata,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output rvx_pkg::t_uop     o_q_uop
);

    rvx_pkg::t_uop r_ent [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    rvx_pkg::t_uop dec;
    logic          push;
    logic          pop;

    always_comb begin
        dec.op  = rvx_pkg::t_op'(i_s_tdata[5:0]);
        dec.rd  = i_s_tdata[10:6];
        dec.rs1 = i_s_tdata[15:11];
        dec.rs2 = i_s_tdata[20:16];
        dec.imm = i_s_tdata[52:21];
        case (dec.op) inside
            [rvx_pkg::OP_ADDI:rvx_pkg::OP_SRAI],
            [rvx_pkg::OP_ADD:rvx_pkg::OP_SRA],
            rvx_pkg::OP_LUI, rvx_pkg::OP_AUIPC:  dec.cls = rvx_pkg::CL_ALU;
            [rvx_pkg::OP_LB:rvx_pkg::OP_LHU]:    dec.cls = rvx_pkg::CL_LOAD;
            [rvx_pkg::OP_SB:rvx_pkg::OP_SW]:     dec.cls = rvx_pkg::CL_STORE;
            [rvx_pkg::OP_BGE:rvx_pkg::OP_BNE]:   dec.cls = rvx_pkg::CL_BRANCH;
            rvx_pkg::OP_JALR, rvx_pkg::OP_JAL:   dec.cls = rvx_pkg::CL_JUMP;
            default:                             dec.cls = rvx_pkg::CL_NONE;
        endcase
    end

    assign o_s_tready = (r_cnt != 2'd2) && !i_hold;
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_valid  = r_cnt != 2'd0;
    assign o_q_uop    = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- rtl/rvx_regfile.sv -----
// ----------------------------------------------------------------------------
// rvx_regfile
// 32 x 32 register file, two registered read ports, per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvx_regfile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_re,
    input  logic [4:0]  i_raddr_a,
    input  logic [4:0]  i_raddr_b,
    output logic [31:0] o_rdata_a,
    output logic [31:0] o_rdata_b,
    input  logic        i_we,
    input  logic [4:0]  i_waddr,
    input  logic [31:0] i_wdata
);

    logic [31:0] r_mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_rdata_a;
    logic [31:0] r_rdata_b;

    // x0 is never written, so its valid bit stays low and it reads zero
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_valid[i_raddr_a] ? r_mem[i_raddr_a] : 32'd0;
            r_rdata_b <= r_valid[i_raddr_b] ? r_mem[i_raddr_b] : 32'd0;
        end
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/rvx_dmem.sv -----
// ----------------------------------------------------------------------------
// rvx_dmem
// Byte data memory in four byte-lane banks; misaligned accesses supported.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvx_dmem #(
    parameter int DMEM_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rvx_pkg::t_mem_req i_req,
    output logic [31:0]       o_rdata,
    output logic              o_busy
);

    localparam int ROWS = (DMEM_BYTES + 3) / 4;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic          r_clr;
    logic [RW-1:0] r_clr_row;
    logic [1:0]    r_a0;
    logic [7:0]    bank_q [4];
    logic [2:0]    nbytes;

    always_comb begin
        case (i_req.size)
            rvx_pkg::MS_BYTE: nbytes = 3'd1;
            rvx_pkg::MS_HALF: nbytes = 3'd2;
            rvx_pkg::MS_WORD: nbytes = 3'd4;
            default:          nbytes = 3'd4;
        endcase
    end

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0]    r_mem [ROWS];
        logic [7:0]    r_q;
        logic [1:0]    off;
        logic [31:0]   full;
        logic [RW-1:0] row;
        logic          en;
        logic [7:0]    wbyte;

        assign off   = 2'(k) - i_req.addr[1:0];
        assign full  = i_req.addr + 32'(off);
        assign row   = full[RW+1:2];
        assign en    = {1'b0, off} < nbytes;
        assign wbyte = 8'(i_req.wdata >> {off, 3'b000});

        always_ff @(posedge i_clk) begin
            if (r_clr) begin
                r_mem[r_clr_row] <= 8'd0;
            end else if (i_req.we && en) begin
                r_mem[row] <= wbyte;
            end
            if (i_req.re) begin
                r_q <= r_mem[row];
            end
        end
        assign bank_q[k] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_a0 <= i_req.addr[1:0];
        end
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_row <= '0;
        end else if (r_clr) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == RW'(ROWS - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_rdata[8*i +: 8] = bank_q[2'(r_a0 + 2'(i))];
        end
    end

    assign o_busy = r_clr;

endmodule

// ----- rtl/rvx_back.sv -----
// ----------------------------------------------------------------------------
// rvx_back
// Executes queued instructions: operand read, execute, write back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rv32i_execute_unit_macros.svh"

module rvx_back #(
    parameter int DMEM_BYTES = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  rvx_pkg::t_uop  i_q_uop,
    output logic           o_busy,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [111:0]   o_m_tdata
);

    localparam logic [32:0] MEM_LIMIT = 33'(DMEM_BYTES);

    rvx_pkg::t_state   r_state, n_state;
    rvx_pkg::t_uop     r_uop;
    logic [31:0]       r_pc;
    logic [31:0]       r_npc, r_val, r_addr;
    logic              r_wr, r_taken, r_err;
    logic [1:0]        r_access;
    logic              r_out_valid;
    logic [111:0]      r_out;

    logic [31:0]       rs_a, rs_b, ld_raw;
    logic              rf_re, rf_we, go;
    logic [4:0]        rf_waddr;
    logic [31:0]       rf_wdata;
    rvx_pkg::t_mem_req mreq;

    logic [31:0]       sum, x_val, x_npc, ld_val, wb_val;
    logic              x_wr, x_taken, x_err, cond, wb_wr;
    logic [1:0]        x_access;
    logic [4:0]        sh_i, sh_r;
    logic [2:0]        nbytes;
    rvx_pkg::t_msize   msize;

    rvx_regfile u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_re      (rf_re),
        .i_raddr_a (i_q_uop.rs1),
        .i_raddr_b (i_q_uop.rs2),
        .o_rdata_a (rs_a),
        .o_rdata_b (rs_b),
        .i_we      (rf_we),
        .i_waddr   (rf_waddr),
        .i_wdata   (rf_wdata)
    );

    rvx_dmem #(.DMEM_BYTES(DMEM_BYTES)) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rdata (ld_raw),
        .o_busy  (o_busy)
    );

    // execute stage
    always_comb begin
        sum      = rs_a + r_uop.imm;
        sh_i     = r_uop.imm[4:0];
        sh_r     = rs_b[4:0];
        x_val    = 32'd0;
        x_wr     = 1'b0;
        x_npc    = r_pc + 32'd4;
        x_taken  = 1'b0;
        cond     = 1'b0;
        x_access = rvx_pkg::ACC_NONE;
        case (r_uop.op)
            rvx_pkg::OP_SB, rvx_pkg::OP_LB, rvx_pkg::OP_LBU: msize = rvx_pkg::MS_BYTE;
            rvx_pkg::OP_SH, rvx_pkg::OP_LH, rvx_pkg::OP_LHU: msize = rvx_pkg::MS_HALF;
            default:                                         msize = rvx_pkg::MS_WORD;
        endcase
        case (msize)
            rvx_pkg::MS_BYTE: nbytes = 3'd1;
            rvx_pkg::MS_HALF: nbytes = 3'd2;
            default:          nbytes = 3'd4;
        endcase
        case (r_uop.op)
            rvx_pkg::OP_ADDI:  begin x_val = sum; x_wr = 1'b1; end
            rvx_pkg::OP_SLTI:  begin
                x_val = 32'($signed(rs_a) < $signed(r_uop.imm)); x_wr = 1'b1;
            end
            rvx_pkg::OP_SLTIU: begin x_val = 32'(rs_a < r_uop.imm); x_wr = 1'b1; end
            rvx_pkg::OP_ANDI:  begin x_val = rs_a & r_uop.imm; x_wr = 1'b1; end
            rvx_pkg::OP_ORI:   begin x_val = rs_a | r_uop.imm; x_wr = 1'b1; end
            rvx_pkg::OP_XORI:  begin x_val = rs_a ^ r_uop.imm; x_wr = 1'b1; end
            rvx_pkg::OP_SLLI:  begin x_val = rs_a << sh_i; x_wr = 1'b1; end
            rvx_pkg::OP_SRLI:  begin x_val = rs_a >> sh_i; x_wr = 1'b1; end
            rvx_pkg::OP_SRAI:  begin x_val = $unsigned($signed(rs_a) >>> sh_i); x_wr = 1'b1; end
            rvx_pkg::OP_ADD:   begin x_val = rs_a + rs_b; x_wr = 1'b1; end
            rvx_pkg::OP_SUB:   begin x_val = rs_a - rs_b; x_wr = 1'b1; end
            rvx_pkg::OP_SLT:   begin x_val = 32'($signed(rs_a) < $signed(rs_b)); x_wr = 1'b1; end
            rvx_pkg::OP_SLTU:  begin x_val = 32'(rs_a < rs_b); x_wr = 1'b1; end
            rvx_pkg::OP_AND:   begin x_val = rs_a & rs_b; x_wr = 1'b1; end
            rvx_pkg::OP_OR:    begin x_val = rs_a | rs_b; x_wr = 1'b1; end
            rvx_pkg::OP_XOR:   begin x_val = rs_a ^ rs_b; x_wr = 1'b1; end
            rvx_pkg::OP_SLL:   begin x_val = rs_a << sh_r; x_wr = 1'b1; end
            rvx_pkg::OP_SRL:   begin x_val = rs_a >> sh_r; x_wr = 1'b1; end
            rvx_pkg::OP_SRA:   begin x_val = $unsigned($signed(rs_a) >>> sh_r); x_wr = 1'b1; end
            rvx_pkg::OP_LUI:   begin x_val = r_uop.imm & rvx_pkg::UPPER_MASK; x_wr = 1'b1; end
            rvx_pkg::OP_AUIPC: begin
                x_val = r_pc + (r_uop.imm & rvx_pkg::UPPER_MASK); x_wr = 1'b1;
            end
            rvx_pkg::OP_JALR:  begin
                x_val = r_pc + 32'd4; x_wr = 1'b1;
                x_npc = {sum[31:1], 1'b0}; x_taken = 1'b1;
            end
            rvx_pkg::OP_JAL:   begin
                x_val = r_pc + 32'd4; x_wr = 1'b1;
                x_npc = r_pc + r_uop.imm; x_taken = 1'b1;
            end
            rvx_pkg::OP_BGE:   cond = !($signed(rs_a) < $signed(rs_b));
            rvx_pkg::OP_BLT:   cond = $signed(rs_a) < $signed(rs_b);
            rvx_pkg::OP_BGEU:  cond = rs_a >= rs_b;
            rvx_pkg::OP_BLTU:  cond = rs_a < rs_b;
            rvx_pkg::OP_BEQ:   cond = rs_a == rs_b;
            rvx_pkg::OP_BNE:   cond = rs_a != rs_b;
            default:           x_val = 32'd0;
        endcase
        if (r_uop.cls == rvx_pkg::CL_BRANCH && cond) begin
            x_npc   = r_pc + r_uop.imm;
            x_taken = 1'b1;
        end
        if (r_uop.cls == rvx_pkg::CL_LOAD)  x_access = rvx_pkg::ACC_LOAD;
        if (r_uop.cls == rvx_pkg::CL_STORE) x_access = rvx_pkg::ACC_STORE;
        x_err = (x_access != rvx_pkg::ACC_NONE) &&
                (({1'b0, sum} + 33'(nbytes)) > MEM_LIMIT);
    end

    // load formatting in write back
    always_comb begin
        case (r_uop.op)
            rvx_pkg::OP_LB:  ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
            rvx_pkg::OP_LBU: ld_val = {24'd0, ld_raw[7:0]};
            rvx_pkg::OP_LH:  ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
            rvx_pkg::OP_LHU: ld_val = {16'd0, ld_raw[15:0]};
            default:         ld_val = ld_raw;
        endcase
        if (r_access == rvx_pkg::ACC_LOAD) begin
            wb_wr  = !r_err && (r_uop.rd != 5'd0);
            wb_val = ld_val;
        end else begin
            wb_wr  = r_wr && (r_uop.rd != 5'd0);
            wb_val = r_val;
        end
    end

    assign go = !r_out_valid || i_m_tready;

    always_comb begin
        n_state       = r_state;
        rf_re         = 1'b0;
        o_q_pop       = 1'b0;
        rf_we         = 1'b0;
        rf_waddr      = r_uop.rd;
        rf_wdata      = wb_val;
        mreq.re       = 1'b0;
        mreq.we       = 1'b0;
        mreq.size     = msize;
        mreq.addr     = sum;
        mreq.wdata    = rs_b;
        case (r_state)
            rvx_pkg::ST_RD: begin
                if (i_q_valid && !o_busy) begin
                    rf_re   = 1'b1;
                    o_q_pop = 1'b1;
                    n_state = rvx_pkg::ST_EX;
                end
            end
            rvx_pkg::ST_EX: begin
                mreq.re = (x_access == rvx_pkg::ACC_LOAD) && !x_err;
                n_state = rvx_pkg::ST_WB;
            end
            rvx_pkg::ST_WB: begin
                mreq.addr = r_addr;
                if (go) begin
                    rf_we   = wb_wr;
                    mreq.we = (r_access == rvx_pkg::ACC_STORE) && !r_err;
                    n_state = rvx_pkg::ST_RD;
                end
            end
            default: n_state = rvx_pkg::ST_RD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_uop <= i_q_uop;
        end
        if (r_state == rvx_pkg::ST_EX) begin
            r_npc    <= x_npc;
            r_val    <= x_val;
            r_wr     <= x_wr;
            r_taken  <= x_taken;
            r_access <= x_access;
            r_addr   <= sum;
            r_err    <= x_err;
        end
        if (r_state == rvx_pkg::ST_WB && go) begin
            r_out <= {6'd0, r_err,
                      (r_access != rvx_pkg::ACC_NONE) ? r_addr : 32'd0,
                      r_access, r_taken,
                      wb_wr ? wb_val : 32'd0,
                      wb_wr ? r_uop.rd : 5'd0,
                      wb_wr, r_npc};
        end
        if (!i_rst_n) begin
            r_state     <= rvx_pkg::ST_RD;
            r_pc        <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rvx_pkg::ST_WB && go) begin
                r_pc        <= r_npc;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    `RVX_IMPLY(a_no_x0_write, rf_we, rf_waddr != 5'd0, "write to x0")
    `RVX_IMPLY(a_store_in_wb, mreq.we, r_state == rvx_pkg::ST_WB, "store outside write back")
    `RVX_NEXT(a_rd_to_ex, o_q_pop, r_state == rvx_pkg::ST_EX, "operand read not followed by execute")
    `RVX_IMPLY(a_pop_valid, o_q_pop, i_q_valid && !o_busy, "pop of empty queue or during clear")

endmodule

// ----- rtl/rv32i_execute_unit.sv -----
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// Executes decoded RV32I instructions against local registers and memory.
//
// Usage:
//   s_axis: one decoded instruction per transaction; m_axis: one result per
//   instruction, in order. APB port holds the reset_pc register (address 0).
//   The front queues up to two instructions; the back takes each through
//   operand read, execute and write back in turn, and reads the next one
//   only after the last has left write back. This sequence is set by the
//   register-file and data-memory read ports, both registered, and the
//   dependency of each instruction on the last.
//   After reset the data memory is cleared one 4-byte row a cycle,
//   (DMEM_BYTES+3)/4 rows, with s_tready low; APB writes still accepted.
//   Register valid bits, pc (0) and the result valid flag are cleared at reset.
//   If m_tready is low, one result waits in the output register, the back
//   holds in write back, and the queue keeps accepting until full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32i_execute_unit #(
    parameter int DMEM_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // operation[5:0], dest_reg[10:6], src_reg_a[15:11], src_reg_b[20:16],
    // immediate[52:21], zero fill
    input  logic [55:0]   i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // next_pc[31:0], reg_write[32], written_reg[37:33], written_value[69:38],
    // branch_taken[70], mem_access[72:71], mem_address[104:73],
    // address_error[105], zero fill
    output logic [111:0]  o_m_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [31:0]   r_reset_pc_val;
    logic          busy, q_valid, q_pop;
    rvx_pkg::t_uop q_uop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? r_reset_pc_val : 32'd0;

    // reset_pc is cleared by reset; the pc restarts at zero, as it does not load reset_pc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_pc_val <= 32'd0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
                r_reset_pc_val <= pwdata;
            end
        end
    end

    rvx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (busy),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_uop    (q_uop)
    );

    rvx_back #(.DMEM_BYTES(DMEM_BYTES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q_uop    (q_uop),
        .o_busy     (busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ----- bench/rv32i_execute_unit_checker.sv -----
// ----------------------------------------------------------------------------
// rv32i_execute_unit_checker
// Watches the instruction and result streams and the APB port. Every accepted
// instruction is executed on a local copy of registers, pc and data memory.
// Each result transaction is compared field by field with the oldest
// predicted result. APB reads of reset_pc are checked against the last write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32i_execute_unit_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tready,
    input  logic [55:0]   i_s_tdata,
    input  logic          i_m_tvalid,
    input  logic          i_m_tready,
    input  logic [111:0]  i_m_tdata,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [31:0]   i_pwdata,
    input  logic [31:0]   i_prdata,
    input  logic          i_pready,
    output int            o_errors,
    output int            o_pending
);

    localparam int MEM_BYTES = 4096;

    // lowest field last, to match the tdata packing
    typedef struct packed {
        logic        address_error;
        logic [31:0] mem_address;
        logic [1:0]  mem_access;
        logic        branch_taken;
        logic [31:0] written_value;
        logic [4:0]  written_reg;
        logic        reg_write;
        logic [31:0] next_pc;
    } t_retire;

    logic [31:0] gpr [32];
    logic [31:0] pc_q;
    logic [7:0]  dmem [MEM_BYTES];
    logic [31:0] reset_pc_q;
    t_retire     retire_q [$];

    function automatic logic [31:0] sra32(logic [31:0] v, logic [4:0] sh);
        return $unsigned($signed(v) >>> sh);
    endfunction

    function automatic t_retire execute(logic [55:0] d);
        logic [5:0]  op;
        logic [4:0]  rd;
        logic [31:0] a, b, imm, addr, val, npc;
        int          size;
        logic        wr, taken, cond, err;
        logic [1:0]  acc;
        t_retire     r;
        op    = d[5:0];
        rd    = d[10:6];
        a     = (d[15:11] == 5'd0) ? 32'd0 : gpr[d[15:11]];
        b     = (d[20:16] == 5'd0) ? 32'd0 : gpr[d[20:16]];
        imm   = d[52:21];
        addr  = a + imm;
        npc   = pc_q + 32'd4;
        val   = '0;
        size  = 0;
        wr    = 1'b0;
        taken = 1'b0;
        cond  = 1'b0;
        err   = 1'b0;
        acc   = rvx_pkg::ACC_NONE;
        case (op)
            rvx_pkg::OP_ADDI:  begin val = a + imm; wr = 1'b1; end
            rvx_pkg::OP_SLTI:  begin val = {31'd0, $signed(a) < $signed(imm)}; wr = 1'b1; end
            rvx_pkg::OP_SLTIU: begin val = {31'd0, a < imm}; wr = 1'b1; end
            rvx_pkg::OP_ANDI:  begin val = a & imm; wr = 1'b1; end
            rvx_pkg::OP_ORI:   begin val = a | imm; wr = 1'b1; end
            rvx_pkg::OP_XORI:  begin val = a ^ imm; wr = 1'b1; end
            rvx_pkg::OP_SLLI:  begin val = a << imm[4:0]; wr = 1'b1; end
            rvx_pkg::OP_SRLI:  begin val = a >> imm[4:0]; wr = 1'b1; end
            rvx_pkg::OP_SRAI:  begin val = sra32(a, imm[4:0]); wr = 1'b1; end
            rvx_pkg::OP_LB, rvx_pkg::OP_LH, rvx_pkg::OP_LW,
            rvx_pkg::OP_LBU, rvx_pkg::OP_LHU: begin
                size = (op == rvx_pkg::OP_LB || op == rvx_pkg::OP_LBU) ? 1 :
                       (op == rvx_pkg::OP_LW) ? 4 : 2;
                acc  = rvx_pkg::ACC_LOAD;
                if ({32'd0, addr} + 64'(size) > 64'(MEM_BYTES)) begin
                    err = 1'b1;
                end else begin
                    for (int i = 0; i < size; i++)
                        val[8*i +: 8] = dmem[12'(addr + 32'(i))];
                    if (op == rvx_pkg::OP_LB) val = {{24{val[7]}}, val[7:0]};
                    if (op == rvx_pkg::OP_LH) val = {{16{val[15]}}, val[15:0]};
                    wr = 1'b1;
                end
            end
            rvx_pkg::OP_JALR:  begin
                val = pc_q + 32'd4; wr = 1'b1; npc = addr & ~32'd1; taken = 1'b1;
            end
            rvx_pkg::OP_ADD:   begin val = a + b; wr = 1'b1; end
            rvx_pkg::OP_SUB:   begin val = a - b; wr = 1'b1; end
            rvx_pkg::OP_SLT:   begin val = {31'd0, $signed(a) < $signed(b)}; wr = 1'b1; end
            rvx_pkg::OP_SLTU:  begin val = {31'd0, a < b}; wr = 1'b1; end
            rvx_pkg::OP_AND:   begin val = a & b; wr = 1'b1; end
            rvx_pkg::OP_OR:    begin val = a | b; wr = 1'b1; end
            rvx_pkg::OP_XOR:   begin val = a ^ b; wr = 1'b1; end
            rvx_pkg::OP_SLL:   begin val = a << b[4:0]; wr = 1'b1; end
            rvx_pkg::OP_SRL:   begin val = a >> b[4:0]; wr = 1'b1; end
            rvx_pkg::OP_SRA:   begin val = sra32(a, b[4:0]); wr = 1'b1; end
            rvx_pkg::OP_SB, rvx_pkg::OP_SH, rvx_pkg::OP_SW: begin
                size = (op == rvx_pkg::OP_SB) ? 1 : (op == rvx_pkg::OP_SH) ? 2 : 4;
                acc  = rvx_pkg::ACC_STORE;
                if ({32'd0, addr} + 64'(size) > 64'(MEM_BYTES))
                    err = 1'b1;
                else
                    for (int i = 0; i < size; i++)
                        dmem[12'(addr + 32'(i))] = b[8*i +: 8];
            end
            rvx_pkg::OP_BGE:   cond = !($signed(a) < $signed(b));
            rvx_pkg::OP_BLT:   cond = $signed(a) < $signed(b);
            rvx_pkg::OP_BGEU:  cond = a >= b;
            rvx_pkg::OP_BLTU:  cond = a < b;
            rvx_pkg::OP_BEQ:   cond = a == b;
            rvx_pkg::OP_BNE:   cond = a != b;
            rvx_pkg::OP_LUI:   begin val = imm & rvx_pkg::UPPER_MASK; wr = 1'b1; end
            rvx_pkg::OP_AUIPC: begin val = pc_q + (imm & rvx_pkg::UPPER_MASK); wr = 1'b1; end
            rvx_pkg::OP_JAL:   begin
                val = pc_q + 32'd4; wr = 1'b1; npc = pc_q + imm; taken = 1'b1;
            end
            default: ;
        endcase
        if (cond) begin
            npc   = pc_q + imm;
            taken = 1'b1;
        end
        if (rd == 5'd0) wr = 1'b0;
        if (wr) gpr[rd] = val;
        pc_q = npc;
        r.next_pc       = npc;
        r.reg_write     = wr;
        r.written_reg   = wr ? rd : 5'd0;
        r.written_value = wr ? val : 32'd0;
        r.branch_taken  = taken;
        r.mem_access    = acc;
        r.mem_address   = (acc != rvx_pkg::ACC_NONE) ? addr : 32'd0;
        r.address_error = err;
        return r;
    endfunction

    assign o_pending = retire_q.size();

    always @(posedge i_clk) begin
        t_retire got, exp_r, pred;
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) gpr[i] = '0;
            for (int i = 0; i < MEM_BYTES; i++) dmem[i] = '0;
            pc_q       = '0;
            reset_pc_q = '0;
            retire_q.delete();
            o_errors   = 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    reset_pc_q = i_pwdata;
                end else if (i_prdata !== reset_pc_q) begin
                    $display("%0t reset_pc read: expected %h actual %h",
                             $time, reset_pc_q, i_prdata);
                    o_errors++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pred     = execute(i_s_tdata);
                retire_q = {retire_q, pred};
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[105:0];
                if (retire_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h",
                             $time, got);
                    o_errors++;
                end else begin
                    exp_r = retire_q.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t result mismatch:", $time);
                        $display({"  expected pc=%h we=%b rd=%0d val=%h br=%b",
                                  " acc=%0d addr=%h err=%b"},
                                 exp_r.next_pc, exp_r.reg_write, exp_r.written_reg,
                                 exp_r.written_value, exp_r.branch_taken,
                                 exp_r.mem_access, exp_r.mem_address,
                                 exp_r.address_error);
                        $display({"  actual   pc=%h we=%b rd=%0d val=%h br=%b",
                                  " acc=%0d addr=%h err=%b"},
                                 got.next_pc, got.reg_write, got.written_reg,
                                 got.written_value, got.branch_taken,
                                 got.mem_access, got.mem_address,
                                 got.address_error);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

// ----- bench/rv32i_execute_unit_tb.sv -----
// ----------------------------------------------------------------------------
// rv32i_execute_unit_tb
// Drives decoded instructions into the execute unit: a directed set covering
// loads, stores, memory bounds, shifts, compares, branches and jumps, then
// random instructions biased toward in-range memory traffic. Both stream
// sides idle at random, with one long output hold-off. reset_pc is written
// and read back while the unit is idle. Checking is done in the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32i_execute_unit_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_RANDOM    = 260;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [55:0]   s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [111:0]  m_tdata;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    int errors;
    int pending;
    int cycles = 0;
    int issued = 0;
    bit calm = 1'b0;
    int hold_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    rv32i_execute_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    rv32i_execute_unit_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_pwdata(pwdata), .i_prdata(prdata), .i_pready(pready),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("rv32i_execute_unit_tb: errors");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off
    always @(negedge i_clk) begin
        if (issued == 120 && hold_left == 0) hold_left = 400;
        if (hold_left > 1) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (hold_left == 1 && issued > 120) hold_left = -1;
            m_tready <= calm || ($urandom_range(0, 99) >= 27);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send(logic [5:0] op, logic [4:0] rd, logic [4:0] rs1,
                        logic [4:0] rs2, logic [31:0] imm);
        while (!calm && $urandom_range(0, 99) < 27) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, imm, rs2, rs1, rd, op};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        issued++;
        @(negedge i_clk);
    endtask

    task automatic apb(logic wr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= '0;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic send_random();
        int          pick;
        logic [5:0]  op;
        logic [4:0]  rs1;
        logic [31:0] imm;
        pick = $urandom_range(0, 99);
        rs1  = 5'($urandom_range(0, 31));
        imm  = $urandom;
        if (pick < 35) begin
            op = $urandom_range(0, 1) ?
                 6'($urandom_range(rvx_pkg::OP_SB, rvx_pkg::OP_SW)) :
                 6'($urandom_range(rvx_pkg::OP_LB, rvx_pkg::OP_LHU));
            if ($urandom_range(0, 3) != 0) begin
                rs1 = 5'd0;
                case ($urandom_range(0, 5))
                    0:       imm = $urandom_range(4080, 4100);
                    1:       imm = $urandom;
                    default: imm = $urandom_range(0, 63);
                endcase
            end
        end else if (pick < 39) begin
            op = 6'($urandom_range(37, 63));
        end else begin
            op = 6'($urandom_range(0, 36));
            if ($urandom_range(0, 2) == 0) imm = $urandom_range(0, 40);
        end
        send(op, 5'($urandom_range(0, 31)), rs1, 5'($urandom_range(0, 31)), imm);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        apb(1'b1, 32'hFFFF_FFFF);
        apb(1'b0, 32'd0);

        send(rvx_pkg::OP_ADDI,  1, 0, 0, 32'hFFFF_FFFF);
        send(rvx_pkg::OP_LUI,   2, 0, 0, 32'h8000_0ABC);
        send(rvx_pkg::OP_ADDI,  3, 0, 0, 32'h0000_07FF);
        send(rvx_pkg::OP_SW,    0, 0, 2, 32'd0);
        send(rvx_pkg::OP_SB,    0, 0, 1, 32'd5);
        send(rvx_pkg::OP_LB,    4, 0, 0, 32'd5);
        send(rvx_pkg::OP_LBU,   5, 0, 0, 32'd3);
        send(rvx_pkg::OP_LH,    6, 0, 0, 32'd2);
        send(rvx_pkg::OP_LHU,   7, 0, 0, 32'd2);
        send(rvx_pkg::OP_LW,    8, 0, 0, 32'd3);
        send(rvx_pkg::OP_SH,    0, 0, 1, 32'd4094);
        send(rvx_pkg::OP_SW,    0, 0, 1, 32'd4094);
        send(rvx_pkg::OP_LW,    9, 0, 0, 32'd4095);
        send(rvx_pkg::OP_LBU,   9, 0, 0, 32'hFFFF_FFFF);
        send(rvx_pkg::OP_LHU,  10, 0, 0, 32'd4094);
        send(rvx_pkg::OP_SRAI, 11, 2, 0, 32'd31);
        send(rvx_pkg::OP_SRA,  12, 2, 3, 32'd0);
        send(rvx_pkg::OP_SLT,  13, 2, 3, 32'd0);
        send(rvx_pkg::OP_SLTU, 14, 2, 3, 32'd0);
        send(rvx_pkg::OP_SUB,  15, 0, 1, 32'd0);
        send(rvx_pkg::OP_BGE,  16, 1, 1, 32'hFFFF_FFF8);
        send(rvx_pkg::OP_BGEU, 16, 2, 3, 32'd16);
        send(rvx_pkg::OP_BLT,   0, 2, 3, 32'd12);
        send(rvx_pkg::OP_BNE,   0, 1, 1, 32'd12);
        send(rvx_pkg::OP_JAL,   1, 0, 0, 32'h0000_0102);
        send(rvx_pkg::OP_JALR, 17, 3, 0, 32'd2);
        send(rvx_pkg::OP_AUIPC,18, 0, 0, 32'hFFFF_F123);
        send(rvx_pkg::OP_ADDI,  0, 1, 0, 32'd7);
        send(6'd63,            19, 1, 1, 32'hFFFF_FFFF);

        repeat (N_RANDOM) send_random();
        wait_idle();
        apb(1'b1, 32'd0);
        apb(1'b0, 32'd0);
        apb(1'b1, $urandom);
        apb(1'b0, 32'd0);

        calm = 1'b1;
        repeat (80) send_random();
        calm = 1'b0;
        repeat (N_RANDOM - 80) send_random();
        wait_idle();
        repeat (20) @(negedge i_clk);

        if (errors == 0 && pending == 0)
            $display("rv32i_execute_unit_tb: clean");
        else
            $display("rv32i_execute_unit_tb: errors");
        $finish;
    end

endmodule
